FILE: design/sbw_pkg.sv
// sbw_pkg: shared types and constants for the soft binned weight block.
// Used by sbw_div_cell, sbw_lane and soft_binned_weight. No dependencies.

package sbw_pkg;

    // Fixed-point unity values
    localparam logic [15:0] ONE_Q15 = 16'h8000;
    localparam logic [15:0] ONE_Q12 = 16'h1000;

    // Breakpoint and weight slots in the packed registers
    localparam int PACK_SLOTS = 3;
    localparam int BIN_SLOTS  = PACK_SLOTS + 1;

    // Divider chain: one quotient bit per cell, 15 bits since the offset is
    // always below half the ramp width when the divide is needed
    localparam int QUO_BITS  = 15;
    localparam int DIV_STEPS = QUO_BITS;

    // Lane latency: front register, divider cells, then t, square, product
    // and round registers
    localparam int LANE_LAT = DIV_STEPS + 5;

    localparam logic [63:0] WEIGHT_PACK_RESET = 64'h1000_1000_1000_1000;

    typedef enum logic [2:0] {
        REG_ENABLE          = 3'd0,
        REG_BREAKPOINT_COUNT = 3'd1,
        REG_SOFTNESS        = 3'd2,
        REG_BREAKPOINT_PACK = 3'd3,
        REG_WEIGHT_PACK     = 3'd4
    } cfg_reg_t;

    // Data handed from one divider cell to the next
    typedef struct packed {
        logic [15:0]         rem;
        logic [QUO_BITS-1:0] quo;
        logic                below;
        logic                sat_hi;
        logic                sat_lo;
    } div_data_t;

    typedef logic [BIN_SLOTS-1:0][15:0] mem_set_t;

    typedef struct packed {
        logic [15:0] weight;
        mem_set_t    mem;
    } result_t;

endpackage

FILE: design/sbw_div_cell.sv
// sbw_div_cell: one restoring-division step, registered.
// Depends on sbw_pkg (div_data_t).

module sbw_div_cell (
    input  logic              clk,
    input  logic              adv,
    input  logic [15:0]       softness,
    input  sbw_pkg::div_data_t d_in,
    output sbw_pkg::div_data_t d_out
);

    sbw_pkg::div_data_t data_reg;
    sbw_pkg::div_data_t data_next;
    logic [16:0]        rem2;
    logic               ge;

    always_comb
    begin
        rem2      = {d_in.rem, 1'b0};
        ge        = rem2 >= {1'b0, softness};
        data_next = d_in;
        // remainder stays below the divisor, so 16 bits hold it
        data_next.rem = ge ? 16'(rem2 - {1'b0, softness}) : rem2[15:0];
        data_next.quo = {d_in.quo[sbw_pkg::QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

FILE: design/sbw_lane.sv
// sbw_lane: crossing fraction of one breakpoint, Q1.15, fixed latency.
// Depends on sbw_pkg and sbw_div_cell.

module sbw_lane #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  adv,
    input  logic [VALUE_BITS-1:0] value_x,
    input  logic [15:0]           breakpoint,
    input  logic [15:0]           softness,
    output logic [15:0]           crossing
);

    localparam int MW = (VALUE_BITS > 16) ? VALUE_BITS : 16;
    localparam logic [17:0] SMOOTH_K = 18'h30000; // 3.0 in Q2.16

    logic [MW-1:0]      x_ext;
    logic [MW-1:0]      b_ext;
    logic [MW-1:0]      mag;
    logic               below;
    logic               far;
    sbw_pkg::div_data_t front_reg;
    sbw_pkg::div_data_t front_next;
    sbw_pkg::div_data_t chain [0:sbw_pkg::DIV_STEPS];
    sbw_pkg::div_data_t last;

    logic [15:0] c_val;
    logic [15:0] t_next;
    logic [15:0] t_reg;
    logic        t_hi_reg;
    logic        t_lo_reg;
    logic [31:0] sq_reg;
    logic [17:0] g_reg;
    logic [17:0] g_next;
    logic        sq_hi_reg;
    logic        sq_lo_reg;
    logic [49:0] p_reg;
    logic [49:0] p_next;
    logic        p_hi_reg;
    logic        p_lo_reg;
    logic [50:0] p_round;
    logic [15:0] s_next;
    logic [15:0] s_reg;

    // Front end: side of the breakpoint, offset, early saturation
    always_comb
    begin
        x_ext = MW'(value_x);
        b_ext = MW'(breakpoint);
        below = x_ext < b_ext;
        mag   = below ? (b_ext - x_ext) : (x_ext - b_ext);
        far   = {mag, 1'b0} >= (MW+1)'(softness);
        front_next.rem   = {mag[14:0], 1'b0};
        front_next.quo   = '0;
        front_next.below = below;
        if (softness == 16'd0)
        begin
            front_next.sat_hi = !below;
            front_next.sat_lo = below;
        end
        else
        begin
            front_next.sat_hi = !below && far;
            front_next.sat_lo = below && far;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg <= front_next;
        end
    end

    assign chain[0] = front_reg;

    for (genvar i = 0; i < sbw_pkg::DIV_STEPS; i++)
    begin : g_cell
        sbw_div_cell u_cell (
            .clk      (clk),
            .adv      (adv),
            .softness (softness),
            .d_in     (chain[i]),
            .d_out    (chain[i+1])
        );
    end

    assign last = chain[sbw_pkg::DIV_STEPS];

    // t16: above the breakpoint floor, below it the ceiling is subtracted
    always_comb
    begin
        c_val  = {1'b0, last.quo} + 16'(last.rem != 16'd0);
        t_next = last.below ? (sbw_pkg::ONE_Q15 - c_val)
                            : (sbw_pkg::ONE_Q15 + {1'b0, last.quo});
    end

    assign g_next  = SMOOTH_K - {1'b0, t_reg, 1'b0};
    assign p_next  = sq_reg * g_reg;
    assign p_round = {1'b0, p_reg} + (51'd1 << 32);

    // t16 of zero rounds to zero on its own
    always_comb
    begin
        if (p_hi_reg)
        begin
            s_next = sbw_pkg::ONE_Q15;
        end
        else if (p_lo_reg)
        begin
            s_next = 16'd0;
        end
        else
        begin
            s_next = p_round[48:33];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg     <= t_next;
            t_hi_reg  <= last.sat_hi;
            t_lo_reg  <= last.sat_lo;
            sq_reg    <= t_reg * t_reg;
            g_reg     <= g_next;
            sq_hi_reg <= t_hi_reg;
            sq_lo_reg <= t_lo_reg;
            p_reg     <= p_next;
            p_hi_reg  <= sq_hi_reg;
            p_lo_reg  <= sq_lo_reg;
            s_reg     <= s_next;
        end
    end

    assign crossing = s_reg;

endmodule

FILE: design/soft_binned_weight.sv
// soft_binned_weight: top level, configuration registers, membership and
// weight stages, output skid buffer. Depends on sbw_pkg and sbw_lane.

// One item is taken per clock while value_stall is low; each transaction on
// value_x yields one result transaction. The pipeline length is set by the
// per-breakpoint lane: a chain of 15 divider cells, one quotient bit each,
// followed by the two-multiplier smoothstep and rounding, then the
// membership, product, partial-sum and output registers. An output register
// plus a skid register let a transaction be taken while a result waits;
// value_stall rises only once both are full. Configuration writes are
// always ready and must be made while no transaction is in flight.

module soft_binned_weight #(
    parameter int MAX_BREAKPOINTS = 3,
    parameter int VALUE_BITS      = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  value_valid,
    output logic                  value_stall,
    input  logic [VALUE_BITS-1:0] value_x,

    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [15:0]           weight,
    output logic [15:0]           membership_0,
    output logic [15:0]           membership_1,
    output logic [15:0]           membership_2,
    output logic [15:0]           membership_3,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data
);

    localparam int LANES = (MAX_BREAKPOINTS < sbw_pkg::PACK_SLOTS) ?
                           MAX_BREAKPOINTS : sbw_pkg::PACK_SLOTS;
    localparam logic [1:0] LANE_CAP = 2'(LANES);
    localparam int MW = (VALUE_BITS > 16) ? VALUE_BITS : 16;
    localparam int LAT = sbw_pkg::LANE_LAT;

    // Configuration registers
    logic        enable_reg;
    logic        enable_next;
    logic [1:0]  bp_count_reg;
    logic [1:0]  bp_count_next;
    logic [15:0] softness_reg;
    logic [15:0] softness_next;
    logic [47:0] bp_pack_reg;
    logic [47:0] bp_pack_next;
    logic [63:0] weight_pack_reg;
    logic [63:0] weight_pack_next;

    logic        adv;
    logic [1:0]  n_eff;
    logic [1:0]  hk_next;
    logic        reached;
    logic [MW-1:0] x_ext;

    logic [LAT-1:0] v_pipe_reg;
    logic [1:0]     hk_pipe_reg [LAT];

    logic [15:0] s_all [0:sbw_pkg::BIN_SLOTS];

    sbw_pkg::mem_set_t mem_next;
    sbw_pkg::mem_set_t m_mem_reg;
    logic [1:0]        m_hk_reg;
    logic              m_valid_reg;
    logic [31:0]       prod_next [sbw_pkg::BIN_SLOTS];
    logic [31:0]       w_prod_reg [sbw_pkg::BIN_SLOTS];
    sbw_pkg::mem_set_t w_mem_reg;
    logic [1:0]        w_hk_reg;
    logic              w_valid_reg;
    logic [32:0]       a_sum_reg [2];
    sbw_pkg::mem_set_t a_mem_reg;
    logic [1:0]        a_hk_reg;
    logic              a_valid_reg;

    logic [33:0] acc;
    logic [34:0] rnd;
    logic [15:0] soft_w;
    logic [15:0] hard_w;
    logic        active;
    sbw_pkg::result_t tail;

    logic             result_valid_reg;
    logic             result_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    sbw_pkg::result_t out_reg;
    sbw_pkg::result_t skid_reg;
    logic             out_take;
    logic             load_out;
    logic             load_skid;
    logic             from_skid;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        enable_next      = enable_reg;
        bp_count_next    = bp_count_reg;
        softness_next    = softness_reg;
        bp_pack_next     = bp_pack_reg;
        weight_pack_next = weight_pack_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sbw_pkg::REG_ENABLE:           enable_next      = cfg_data[0];
                sbw_pkg::REG_BREAKPOINT_COUNT: bp_count_next    = cfg_data[1:0];
                sbw_pkg::REG_SOFTNESS:         softness_next    = cfg_data[15:0];
                sbw_pkg::REG_BREAKPOINT_PACK:  bp_pack_next     = cfg_data[47:0];
                sbw_pkg::REG_WEIGHT_PACK:      weight_pack_next = cfg_data;
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            bp_count_reg    <= 2'd0;
            softness_reg    <= 16'd0;
            bp_pack_reg     <= 48'd0;
            weight_pack_reg <= sbw_pkg::WEIGHT_PACK_RESET;
        end
        else
        begin
            enable_reg      <= enable_next;
            bp_count_reg    <= bp_count_next;
            softness_reg    <= softness_next;
            bp_pack_reg     <= bp_pack_next;
            weight_pack_reg <= weight_pack_next;
        end
    end

    assign n_eff = (bp_count_reg > LANE_CAP) ? LANE_CAP : bp_count_reg;

    // ---------------- input side ----------------
    // whole pipeline moves together unless the skid buffer is occupied
    assign adv         = !skid_valid_reg;
    assign value_stall = skid_valid_reg;
    assign x_ext       = MW'(value_x);

    // hard bin: leading breakpoints reached, stop at the first one missed
    always_comb
    begin
        hk_next = 2'd0;
        reached = 1'b1;
        for (int k = 0; k < sbw_pkg::PACK_SLOTS; k++)
        begin
            if (reached && (2'(k) < n_eff) && (x_ext >= MW'(bp_pack_reg[16*k +: 16])))
            begin
                hk_next = hk_next + 2'd1;
            end
            else
            begin
                reached = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_pipe_reg <= '0;
        end
        else if (adv)
        begin
            v_pipe_reg <= {v_pipe_reg[LAT-2:0], value_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hk_pipe_reg[0] <= hk_next;
            for (int i = 1; i < LAT; i++)
            begin
                hk_pipe_reg[i] <= hk_pipe_reg[i-1];
            end
        end
    end

    // ---------------- breakpoint lanes ----------------
    assign s_all[0]                  = sbw_pkg::ONE_Q15;
    assign s_all[sbw_pkg::BIN_SLOTS] = 16'd0;

    for (genvar k = 0; k < sbw_pkg::PACK_SLOTS; k++)
    begin : g_lane
        if (k < LANES)
        begin : g_used
            sbw_lane #(
                .VALUE_BITS (VALUE_BITS)
            ) u_lane (
                .clk        (clk),
                .adv        (adv),
                .value_x    (value_x),
                .breakpoint (bp_pack_reg[16*k +: 16]),
                .softness   (softness_reg),
                .crossing   (s_all[k+1])
            );
        end
        else
        begin : g_unused
            assign s_all[k+1] = 16'd0;
        end
    end

    // ---------------- memberships ----------------
    always_comb
    begin
        for (int k = 0; k < sbw_pkg::BIN_SLOTS; k++)
        begin
            if (3'(k) < {1'b0, n_eff})
            begin
                mem_next[k] = (s_all[k] >= s_all[k+1]) ? (s_all[k] - s_all[k+1]) : 16'd0;
            end
            else if (3'(k) == {1'b0, n_eff})
            begin
                mem_next[k] = s_all[k];
            end
            else
            begin
                mem_next[k] = 16'd0;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < sbw_pkg::BIN_SLOTS; k++)
        begin
            prod_next[k] = weight_pack_reg[16*k +: 16] * m_mem_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= v_pipe_reg[LAT-1];
            w_valid_reg <= m_valid_reg;
            a_valid_reg <= w_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_mem_reg    <= mem_next;
            m_hk_reg     <= hk_pipe_reg[LAT-1];
            w_prod_reg   <= prod_next;
            w_mem_reg    <= m_mem_reg;
            w_hk_reg     <= m_hk_reg;
            a_sum_reg[0] <= {1'b0, w_prod_reg[0]} + {1'b0, w_prod_reg[1]};
            a_sum_reg[1] <= {1'b0, w_prod_reg[2]} + {1'b0, w_prod_reg[3]};
            a_mem_reg    <= w_mem_reg;
            a_hk_reg     <= w_hk_reg;
        end
    end

    // ---------------- weight ----------------
    always_comb
    begin
        acc    = {1'b0, a_sum_reg[0]} + {1'b0, a_sum_reg[1]};
        rnd    = {1'b0, acc} + 35'd16384;
        soft_w = (|rnd[34:31]) ? 16'hFFFF : rnd[30:15];
        hard_w = weight_pack_reg[{a_hk_reg, 4'b0000} +: 16];
        active = 1'b0;
        for (int k = 0; k < sbw_pkg::BIN_SLOTS; k++)
        begin
            if ((3'(k) <= {1'b0, n_eff}) && (weight_pack_reg[16*k +: 16] != sbw_pkg::ONE_Q12))
            begin
                active = 1'b1;
            end
        end
        active = active && enable_reg;

        tail.mem = a_mem_reg;
        if (!active)
        begin
            tail.weight = sbw_pkg::ONE_Q12;
        end
        else if (softness_reg == 16'd0)
        begin
            tail.weight = hard_w;
        end
        else
        begin
            tail.weight = soft_w;
        end
    end

    // ---------------- output register and skid ----------------
    assign out_take = result_valid_reg && !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        skid_valid_next   = skid_valid_reg;
        load_out          = 1'b0;
        load_skid         = 1'b0;
        from_skid         = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                load_out        = 1'b1;
                from_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (a_valid_reg)
        begin
            if (!result_valid_reg || out_take)
            begin
                load_out          = 1'b1;
                result_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= from_skid ? skid_reg : tail;
        end
        if (load_skid)
        begin
            skid_reg <= tail;
        end
    end

    assign result_valid = result_valid_reg;
    assign weight       = out_reg.weight;
    assign membership_0 = out_reg.mem[0];
    assign membership_1 = out_reg.mem[1];
    assign membership_2 = out_reg.mem[2];
    assign membership_3 = out_reg.mem[3];

    // ---------------- assertions ----------------
    a_skid_implies_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg
    ) else $error("skid holds a transaction while the output register is empty");

    a_skid_fill_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(result_valid_reg && result_stall)
    ) else $error("skid filled without a stalled output");

    a_take_drains_skid: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_stall) |=> !skid_valid_reg
    ) else $error("skid still occupied after the output was taken");

endmodule
